/* sv/sawtc_pkg.sv */
// ----------------------------------------------------------------------------
// sawtc_pkg
// Shared types and constants for the set-associative write-through cache.
// ----------------------------------------------------------------------------
package sawtc_pkg;

  localparam int DEF_LINE_BYTES = 64;
  localparam int DEF_NUM_SETS   = 128;
  localparam int DEF_NUM_WAYS   = 8;
  localparam int DEF_MEM_BYTES  = 65536;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_ONE  = 16'h0001;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] MAX_LEN = 3'd4;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [2:0]  len;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctl_sts_t;

endpackage

/* sv/sawtc_datapath.sv */
// ----------------------------------------------------------------------------
// sawtc_datapath
// Tag store, byte-lane backing memory banks, replacement LFSR, result register.
// ----------------------------------------------------------------------------
module sawtc_datapath #(
  parameter int LINE_BYTES = sawtc_pkg::DEF_LINE_BYTES,
  parameter int NUM_SETS   = sawtc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS   = sawtc_pkg::DEF_NUM_WAYS,
  parameter int MEM_BYTES  = sawtc_pkg::DEF_MEM_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  sawtc_pkg::ctl_cmd_t cmd,
  output sawtc_pkg::ctl_sts_t sts,
  input  sawtc_pkg::req_t     in_data,
  output sawtc_pkg::rsp_t     out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  localparam int AW       = $clog2(MEM_BYTES);
  localparam int LOG_LINE = $clog2(LINE_BYTES);
  localparam int LOG_SETS = $clog2(NUM_SETS);
  localparam int SETW     = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int TAG_BITS = AW - LOG_LINE - LOG_SETS;
  localparam int TAGW     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int ENTW     = TAGW + 1;
  localparam int ROWW     = NUM_WAYS * ENTW;
  localparam int LOG_WAYS = $clog2(NUM_WAYS);
  localparam int WAYW     = (LOG_WAYS > 0) ? LOG_WAYS : 1;
  localparam int ROWS     = MEM_BYTES / 4;
  localparam int CLR_N    = (ROWS > NUM_SETS) ? ROWS : NUM_SETS;
  localparam int CLRW     = $clog2(CLR_N);
  localparam int RW       = AW - 2;

  sawtc_pkg::req_t req_q;
  logic [CLRW-1:0] clr_cnt;
  logic [15:0]     lfsr;
  logic [ROWW-1:0] tag_mem [NUM_SETS];
  logic [ROWW-1:0] tag_row;
  logic [7:0]      rd_byte [4];

  logic [AW-1:0]   a;
  logic [2:0]      n;
  logic [SETW-1:0] set_idx;
  logic [TAGW-1:0] tag;
  logic            hit;
  logic            all_valid;
  logic [WAYW-1:0] free_way;
  logic [WAYW-1:0] victim;
  logic [ROWW-1:0] new_row;
  logic [31:0]     rdata;
  logic            fill;

  assign a       = AW'(req_q.addr);
  assign n       = (req_q.len > sawtc_pkg::MAX_LEN) ? sawtc_pkg::MAX_LEN : req_q.len;
  assign set_idx = SETW'((a >> LOG_LINE) & AW'(NUM_SETS - 1));
  assign tag     = TAGW'(a >> (LOG_LINE + LOG_SETS));
  assign sts.clear_last = (clr_cnt == CLRW'(CLR_N - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // lookup over the ways of the set, plus first-invalid search
  always_comb begin
    hit       = 1'b0;
    all_valid = 1'b1;
    free_way  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_row[w*ENTW + TAGW] && tag_row[w*ENTW +: TAGW] == tag) begin
        hit = 1'b1;
      end
      if (!tag_row[w*ENTW + TAGW]) begin
        all_valid = 1'b0;
        free_way  = WAYW'(w);
      end
    end
  end

  assign victim = all_valid ? WAYW'(lfsr & 16'(NUM_WAYS - 1)) : free_way;
  assign fill   = cmd.update && (req_q.op == sawtc_pkg::OP_READ) && !hit;

  always_comb begin
    new_row = tag_row;
    new_row[victim*ENTW +: ENTW] = {1'b1, tag};
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && {1'b0, clr_cnt} < (CLRW+1)'(NUM_SETS)) begin
      tag_mem[SETW'(clr_cnt)] <= '0;
    end else if (fill) begin
      tag_mem[set_idx] <= new_row;
    end
    tag_row <= tag_mem[set_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sawtc_pkg::SEED_ONE;
    end else if (cfg_we) begin
      lfsr <= (cfg_wdata == 16'd0) ? sawtc_pkg::SEED_ONE : cfg_wdata;
    end else if (fill && all_valid) begin
      lfsr <= lfsr[0] ? ((lfsr >> 1) ^ sawtc_pkg::LFSR_TAPS) : (lfsr >> 1);
    end
  end

  // four byte-lane banks: lane b holds addresses with addr mod 4 == b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    k;
    logic [AW-1:0] ba;
    logic          en;

    assign k  = 2'(b) - a[1:0];
    assign ba = a + AW'(k);
    assign en = ({1'b0, k} < n);

    always_ff @(posedge clk) begin
      if (cmd.clear && {1'b0, clr_cnt} < (CLRW+1)'(ROWS)) begin
        mem[RW'(clr_cnt)] <= '0;
      end else if (cmd.update && req_q.op == sawtc_pkg::OP_WRITE && en) begin
        mem[ba[AW-1:2]] <= req_q.wdata[8*k +: 8];
      end
      rd_byte[b] <= mem[ba[AW-1:2]];
    end
  end

  // valid lines always mirror memory under write-through, so read data
  // comes from the banks for hit and miss alike
  always_comb begin
    rdata = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n && req_q.op == sawtc_pkg::OP_READ) begin
        rdata[8*k +: 8] = rd_byte[2'(a[1:0] + 2'(k))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data.rdata <= rdata;
      out_data.hit   <= hit;
    end
  end

endmodule

/* sv/sawtc_ctrl.sv */
// ----------------------------------------------------------------------------
// sawtc_ctrl
// Sequencer: memory clear after reset, capture, lookup, update, response.
// ----------------------------------------------------------------------------
module sawtc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sawtc_pkg::ctl_cmd_t cmd,
  input  sawtc_pkg::ctl_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_UPD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready    = (state == S_IDLE) && !out_valid;
  assign cmd.clear   = (state == S_CLEAR);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.update  = (state == S_UPD);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid && in_ready) state_next = S_LOOK;
      S_LOOK:  state_next = S_UPD;
      S_UPD:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_LOOK)
    else $error("accepted transaction did not start lookup");

  a_upd_resp: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |=> out_valid)
    else $error("update did not raise response");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && !sts.clear_last |=> state == S_CLEAR && !in_ready)
    else $error("clear pass ended early");

endmodule

/* sv/set_assoc_write_through_cache.sv */
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache
// Set-associative write-through cache with internal backing memory.
// ----------------------------------------------------------------------------
// Sequence: an accepted request passes through the lookup state (read of tag
//   row and memory banks) and the update state, after which result valid is registered.
// One transaction at a time: no new input until the result has been taken.
// Reset: a clearing pass over max(MEM_BYTES/4, NUM_SETS) rows zeroes the
//   memory banks and tag store; no input is taken until it ends.
module set_assoc_write_through_cache #(
  parameter int LINE_BYTES = sawtc_pkg::DEF_LINE_BYTES,
  parameter int NUM_SETS   = sawtc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS   = sawtc_pkg::DEF_NUM_WAYS,
  parameter int MEM_BYTES  = sawtc_pkg::DEF_MEM_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sawtc_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sawtc_pkg::rsp_t out_data,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);

  sawtc_pkg::ctl_cmd_t cmd;
  sawtc_pkg::ctl_sts_t sts;

  sawtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sawtc_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .MEM_BYTES  (MEM_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

/* tb/sv/cache_checker.sv */
// ----------------------------------------------------------------------------
// cache_checker
// Watches the request and response channels of the write-through cache,
// keeps its own copy of memory, tags and replacement LFSR, and compares each
// response with the oldest predicted one.
// ----------------------------------------------------------------------------
module cache_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  sawtc_pkg::req_t in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  sawtc_pkg::rsp_t out_data,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  output int              err_count,
  output int              pending,
  output int              reads_seen,
  output int              hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB = sawtc_pkg::DEF_LINE_BYTES;
  localparam int NS = sawtc_pkg::DEF_NUM_SETS;
  localparam int NW = sawtc_pkg::DEF_NUM_WAYS;
  localparam int MB = sawtc_pkg::DEF_MEM_BYTES;

  logic [7:0]      mem_model [MB];
  logic [7:0]      line_data [NS*NW][LB];
  logic            line_ok   [NS*NW];
  logic [15:0]     line_tag  [NS*NW];
  logic [15:0]     lfsr;
  sawtc_pkg::rsp_t rsp_queue [$];

  function automatic int lookup(int b);
    int ln, st;
    ln = b / LB;
    st = ln % NS;
    for (int w = 0; w < NW; w++)
      if (line_ok[st*NW+w] && line_tag[st*NW+w] == 16'(ln / NS)) return st*NW + w;
    return -1;
  endfunction

  function automatic void fill(int b);
    int ln, st, way, s, base;
    ln = b / LB;
    st = ln % NS;
    base = b - b % LB;
    way = NW;
    for (int w = 0; w < NW; w++)
      if (!line_ok[st*NW+w]) begin
        way = w;
        break;
      end
    if (way == NW) begin
      way = int'(lfsr) % NW;
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ sawtc_pkg::LFSR_TAPS) : (lfsr >> 1);
    end
    s = st*NW + way;
    for (int i = 0; i < LB; i++) line_data[s][i] = mem_model[(base + i) % MB];
    line_ok[s] = 1'b1;
    line_tag[s] = 16'(ln / NS);
  endfunction

  function automatic sawtc_pkg::rsp_t cache_access(sawtc_pkg::req_t r);
    sawtc_pkg::rsp_t p;
    int a, n, off, slot, b, s;
    logic [7:0] v;
    a = int'(r.addr) % MB;
    n = (r.len > sawtc_pkg::MAX_LEN) ? 4 : int'(r.len);
    off = a % LB;
    p = '0;
    slot = lookup(a);
    if (r.op == sawtc_pkg::OP_READ) begin
      if (slot < 0) fill(a);
      for (int k = 0; k < n; k++) begin
        if (slot >= 0 && off + k < LB) v = line_data[slot][off+k];
        else v = mem_model[(a + k) % MB];
        p.rdata[8*k +: 8] = v;
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        b = (a + k) % MB;
        v = r.wdata[8*k +: 8];
        s = lookup(b);
        mem_model[b] = v;
        if (s >= 0) line_data[s][b % LB] = v;
      end
    end
    p.hit = (slot >= 0);
    return p;
  endfunction

  task automatic report(string what, sawtc_pkg::rsp_t got, sawtc_pkg::rsp_t want);
    $display("cache_checker: %s got rdata=%h hit=%b want rdata=%h hit=%b",
             what, got.rdata, got.hit, want.rdata, want.hit);
    err_count++;
  endtask

  initial begin
    err_count = 0;
    pending = 0;
    reads_seen = 0;
    hits_seen = 0;
    lfsr = sawtc_pkg::SEED_ONE;
    foreach (mem_model[i]) mem_model[i] = '0;
    foreach (line_ok[i]) begin
      line_ok[i] = 1'b0;
      line_tag[i] = '0;
    end
  end

  always @(posedge clk) begin
    sawtc_pkg::rsp_t want;
    if (rst) begin
      lfsr <= sawtc_pkg::SEED_ONE;
    end else begin
      // response first: a same-edge request cannot affect an older response
      if (out_valid && out_ready) begin
        if (rsp_queue.size() == 0) begin
          report("unexpected transaction", out_data, '0);
        end else begin
          want = rsp_queue.pop_front();
          if (out_data.rdata !== want.rdata || out_data.hit !== want.hit)
            report("mismatch", out_data, want);
        end
      end
      if (cfg_we) lfsr = (cfg_wdata == 16'd0) ? sawtc_pkg::SEED_ONE : cfg_wdata;
      if (in_valid && in_ready) begin
        want = cache_access(in_data);
        if (in_data.op == sawtc_pkg::OP_READ) reads_seen++;
        if (want.hit) hits_seen++;
        rsp_queue.push_back(want);
      end
    end
    pending = rsp_queue.size();
  end
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Random and directed reads and writes against the write-through cache,
// with random idling on both sides, a long output hold-off, and several
// replacement seeds written between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  sawtc_pkg::req_t in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  sawtc_pkg::rsp_t out_data;
  logic            cfg_we = 1'b0;
  logic [15:0]     cfg_wdata = '0;
  int              err_count, pending, reads_seen, hits_seen;
  bit              quiet_in, quiet_out, hold_out;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_write_through_cache dut (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  cache_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_wdata, .err_count, .pending, .reads_seen, .hits_seen
  );

  // receiver: random stalls, none while quiet, held off entirely during a hold-off
  always @(posedge clk) begin
    if (hold_out) out_ready <= 1'b0;
    else out_ready <= quiet_out || ($urandom_range(99) >= 8);
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send(sawtc_pkg::req_t r);
    while (!quiet_in && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_seed(logic [15:0] s);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sawtc_pkg::req_t rand_req(int hot);
    sawtc_pkg::req_t r;
    r.op = ($urandom_range(1) != 0) ? sawtc_pkg::OP_WRITE : sawtc_pkg::OP_READ;
    // hot: eight tags per set, one per way, so repeated lines hit
    if (hot) r.addr = {4'($urandom_range(15)), 12'($urandom)};
    else r.addr = 16'($urandom);
    if (hot && $urandom_range(3) == 0) r.addr[5:0] = 6'd60 + 6'($urandom_range(3));
    r.len = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    r.wdata = $urandom;
    return r;
  endfunction

  initial begin
    quiet_in = 0;
    quiet_out = 0;
    hold_out = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_seed(16'hFFFF);
    // directed: extremes, line crossing, memory wrap, lengths 0 and above 4
    send('{sawtc_pkg::OP_WRITE, 16'h0000, 3'd4, 32'hDEADBEEF});
    send('{sawtc_pkg::OP_READ,  16'h0000, 3'd4, 32'h0});
    send('{sawtc_pkg::OP_READ,  16'h0000, 3'd4, 32'hFFFFFFFF});
    send('{sawtc_pkg::OP_WRITE, 16'h0002, 3'd2, 32'hFFFFA5C3});
    send('{sawtc_pkg::OP_READ,  16'h0000, 3'd7, 32'h0});
    send('{sawtc_pkg::OP_WRITE, 16'hFFFE, 3'd4, 32'h11223344});
    send('{sawtc_pkg::OP_READ,  16'hFFFF, 3'd4, 32'h0});
    send('{sawtc_pkg::OP_READ,  16'h0001, 3'd1, 32'h0});
    send('{sawtc_pkg::OP_WRITE, 16'h003E, 3'd4, 32'hCAFEF00D});
    send('{sawtc_pkg::OP_READ,  16'h003E, 3'd4, 32'h0});
    send('{sawtc_pkg::OP_READ,  16'h0040, 3'd2, 32'h0});
    send('{sawtc_pkg::OP_WRITE, 16'h007F, 3'd3, 32'h00ABCDEF});
    send('{sawtc_pkg::OP_READ,  16'h003D, 3'd4, 32'h0});
    send('{sawtc_pkg::OP_READ,  16'h1000, 3'd0, 32'h0});
    send('{sawtc_pkg::OP_WRITE, 16'h1000, 3'd0, 32'hFFFFFFFF});
    send('{sawtc_pkg::OP_READ,  16'h8000, 3'd5, 32'h0});
    // fill all ways of set 0, then hit on a wrapped address
    for (int t = 0; t < 9; t++) send('{sawtc_pkg::OP_READ, 16'(t * 16'h2000), 3'd1, 32'h0});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_seed(16'h0001);
        1: set_seed(16'h0000);
        2: set_seed(16'hFFFF);
        default: set_seed(16'($urandom_range(1, 65535)));
      endcase
      quiet_in = (ph == 1);
      quiet_out = (ph == 1);
      fork
        begin
          for (int i = 0; i < 400; i++) send(rand_req($urandom_range(9) != 0));
        end
        begin
          if (ph == 2) begin
            repeat (30) @(posedge clk);
            hold_out = 1;
            repeat (300) @(posedge clk);
            hold_out = 0;
          end
        end
      join
      drain();
    end
    $display("tb_top: %0d reads, %0d hits over five seeds incl. 0, 1 and 65535",
             reads_seen, hits_seen);
    $display("tb_top: line crossings, memory wrap, lengths 0..7, full sets, stalls");
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule

/* filelist.f */
sv/sawtc_pkg.sv
sv/sawtc_datapath.sv
sv/sawtc_ctrl.sv
sv/set_assoc_write_through_cache.sv
tb/sv/cache_checker.sv
tb/sv/tb_top.sv
